/* hw/rtl/vector_matrix_multiply_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the vector-matrix multiply block
// Shared concurrent check forms, clocked on clk with async reset arst_n.
// ----------------------------------------------------------------------------
`ifndef VECTOR_MATRIX_MULTIPLY_DEFINES_SVH
`define VECTOR_MATRIX_MULTIPLY_DEFINES_SVH

// same-cycle implication
`define VMM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vmm check failed");

// next-cycle implication
`define VMM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vmm check failed");

`endif

/* hw/rtl/vmm_pkg.sv */
// ----------------------------------------------------------------------------
// vmm_pkg
// Types and constants shared by the vector-matrix multiply block.
// ----------------------------------------------------------------------------
package vmm_pkg;

	localparam int MAX_COLUMNS_DEF = 16;
	localparam int LANE_CAP        = 16;   // columns a 4-bit index can address
	localparam int COL_W           = 4;
	localparam int NCOL_W          = 5;
	localparam int DATA_W          = 16;
	localparam int PROD_W          = 32;
	localparam int ACC_W           = 48;
	localparam int CMD_DEPTH       = 4;
	localparam int RES_DEPTH       = 2;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	typedef struct packed {
		logic signed [DATA_W-1:0] matrix_element;
		logic        [COL_W-1:0]  column_index;
		logic signed [DATA_W-1:0] row_factor;
		logic                     last_element;
	} item_t;

	typedef struct packed {
		logic        [COL_W-1:0] result_column;
		logic signed [ACC_W-1:0] column_sum;
		logic                    last_result;
	} result_t;

	// command passed from the front end to the back end
	typedef struct packed {
		logic                     acc_en;
		logic                     last;
		logic        [COL_W-1:0]  col;
		logic signed [PROD_W-1:0] product;
	} cmd_t;

endpackage

/* hw/rtl/vmm_fifo.sv */
// ----------------------------------------------------------------------------
// vmm_fifo
// Small register-based FIFO with show-ahead read data.
// ----------------------------------------------------------------------------
`include "vector_matrix_multiply_defines.svh"

module vmm_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr, do_rd;

	assign full    = (count_q == CNT_FULL);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	`VMM_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_FULL)

endmodule

/* hw/rtl/vmm_front.sv */
// ----------------------------------------------------------------------------
// vmm_front
// Accepts matrix elements, drops out-of-range columns (unless flagged last), forms the product.
// ----------------------------------------------------------------------------
module vmm_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [vmm_pkg::NCOL_W-1:0] ncols,
	input  logic                       push,
	output logic                       full,
	input  vmm_pkg::item_t             item,
	output logic                       q_push,
	output vmm_pkg::cmd_t              q_data,
	input  logic                       q_full
);
	import vmm_pkg::*;

	logic                     valid_s1;
	logic                     acc_en_s1;
	logic                     last_s1;
	logic        [COL_W-1:0]  col_s1;
	logic signed [DATA_W-1:0] elem_s1;
	logic signed [DATA_W-1:0] factor_s1;
	logic                     accept;
	logic                     in_range;

	assign full     = valid_s1 && q_full;
	assign accept   = push && !full;
	assign in_range = ({1'b0, item.column_index} < ncols);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			// an out-of-range element only survives if it carries the last flag
			valid_s1 <= in_range || item.last_element;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			acc_en_s1 <= in_range;
			last_s1   <= item.last_element;
			col_s1    <= item.column_index;
			elem_s1   <= item.matrix_element;
			factor_s1 <= item.row_factor;
		end
	end

	assign q_push         = valid_s1 && !q_full;
	assign q_data.acc_en  = acc_en_s1;
	assign q_data.last    = last_s1;
	assign q_data.col     = col_s1;
	assign q_data.product = elem_s1 * factor_s1;

endmodule

/* hw/rtl/vmm_back.sv */
// ----------------------------------------------------------------------------
// vmm_back
// Column accumulators with saturation and the drain sequencer.
// ----------------------------------------------------------------------------
`include "vector_matrix_multiply_defines.svh"

module vmm_back #(
	parameter int LANES = vmm_pkg::LANE_CAP
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [vmm_pkg::NCOL_W-1:0] ncols,
	input  vmm_pkg::cmd_t              q_data,
	input  logic                       q_empty,
	output logic                       q_pop,
	output logic                       res_push,
	output vmm_pkg::result_t           res_data,
	input  logic                       res_full
);
	import vmm_pkg::*;

	localparam int LANE_W = (LANES > 1) ? $clog2(LANES) : 1;

	typedef enum logic {
		ST_ACCUM,
		ST_DRAIN
	} state_t;

	state_t                  state_q;
	logic [LANE_W-1:0]       idx_q;
	logic [LANES-1:0]        acc_valid_q;
	logic signed [ACC_W-1:0] acc_q [LANES];

	logic [LANE_W-1:0]       rd_idx;
	logic signed [ACC_W-1:0] acc_rd;
	logic signed [ACC_W:0]   sum_wide;
	logic signed [ACC_W-1:0] sum_sat;
	logic                    acc_wr;
	logic                    drain_last;

	assign q_pop    = (state_q == ST_ACCUM) && !q_empty;
	assign res_push = (state_q == ST_DRAIN) && !res_full;
	assign acc_wr   = q_pop && q_data.acc_en;

	// single read port, shared by accumulate and drain
	assign rd_idx = (state_q == ST_DRAIN) ? idx_q : q_data.col[LANE_W-1:0];
	assign acc_rd = acc_valid_q[rd_idx] ? acc_q[rd_idx] : '0;

	always_comb begin
		sum_wide = {acc_rd[ACC_W-1], acc_rd}
			+ {{(ACC_W + 1 - PROD_W){q_data.product[PROD_W-1]}}, q_data.product};
		if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
			sum_sat = sum_wide[ACC_W] ? ACC_MIN : ACC_MAX;
		end else begin
			sum_sat = sum_wide[ACC_W-1:0];
		end
	end

	assign drain_last = ((NCOL_W'(idx_q) + NCOL_W'(1)) == ncols);

	assign res_data.result_column = COL_W'(idx_q);
	assign res_data.column_sum    = acc_rd;
	assign res_data.last_result   = drain_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACCUM;
			idx_q       <= '0;
			acc_valid_q <= '0;
		end else begin
			case (state_q)
				ST_ACCUM: begin
					if (acc_wr) begin
						acc_valid_q[rd_idx] <= 1'b1;
					end
					if (q_pop && q_data.last) begin
						idx_q <= '0;
						if (ncols == '0) begin
							acc_valid_q <= '0;
						end else begin
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (res_push) begin
						if (drain_last) begin
							acc_valid_q <= '0;
							state_q     <= ST_ACCUM;
						end else begin
							idx_q <= idx_q + LANE_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_ACCUM;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc_wr) begin
			acc_q[rd_idx] <= sum_sat;
		end
	end

	`VMM_ASSERT_NOW(a_no_pop_in_drain, state_q == ST_DRAIN, !q_pop)
	`VMM_ASSERT_NEXT(a_clear_after_drain, res_push && drain_last, acc_valid_q == '0)

endmodule

/* hw/rtl/vector_matrix_multiply.sv */
// ----------------------------------------------------------------------------
// vector_matrix_multiply
// Streaming row-vector by matrix product with saturating 48-bit sums.
// ----------------------------------------------------------------------------
// Takes one matrix element per cycle while full is low; each goes through the
// front register and command queue before adding x*A into its column's sum.
// A beat flagged last releases one sum per column in use through the result
// queue, one per cycle while it has room; during that drain the single
// accumulator read port is busy, so incoming elements wait in a four-entry
// command queue behind the front register and push stalls once both fill.
// Column count is written through the cfg channel (always ready); the user
// must write it only while the block is idle; the block does not enforce it.
module vector_matrix_multiply #(
	parameter int MAX_COLUMNS = vmm_pkg::MAX_COLUMNS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [vmm_pkg::NCOL_W-1:0] cfg_data,
	input  logic                       push,
	output logic                       full,
	input  vmm_pkg::item_t             item,
	input  logic                       pop,
	output logic                       empty,
	output vmm_pkg::result_t           result
);
	import vmm_pkg::*;

	localparam int LANES = (MAX_COLUMNS < LANE_CAP) ? MAX_COLUMNS : LANE_CAP;
	localparam logic [NCOL_W-1:0] LANES_N = NCOL_W'(LANES);

	logic [NCOL_W-1:0] columns_in_use_q;
	logic [NCOL_W-1:0] ncols;
	logic              q_push, q_full, q_pop, q_empty;
	cmd_t              q_wr, q_rd;
	logic              res_push, res_full;
	result_t           res_wr;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_in_use_q <= NCOL_W'(16);
		end else if (cfg_valid && cfg_ready) begin
			columns_in_use_q <= cfg_data;
		end
	end

	assign ncols = (columns_in_use_q > LANES_N) ? LANES_N : columns_in_use_q;

	vmm_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.ncols  (ncols),
		.push   (push),
		.full   (full),
		.item   (item),
		.q_push (q_push),
		.q_data (q_wr),
		.q_full (q_full)
	);

	vmm_fifo #(
		.WIDTH ($bits(cmd_t)),
		.DEPTH (CMD_DEPTH)
	) u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wr),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (q_rd),
		.empty   (q_empty)
	);

	vmm_back #(
		.LANES (LANES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.ncols    (ncols),
		.q_data   (q_rd),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.res_push (res_push),
		.res_data (res_wr),
		.res_full (res_full)
	);

	vmm_fifo #(
		.WIDTH ($bits(result_t)),
		.DEPTH (RES_DEPTH)
	) u_res_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_wr),
		.full    (res_full),
		.rd_en   (pop),
		.rd_data (result),
		.empty   (empty)
	);

endmodule
